// File: hdl/lkv_pkg.sv
// shared types and constants for the lru key/value cache
// no dependencies; imported by every module of the block
package lkv_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int CAP_W           = 5;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [VAL_W-1:0] MISS_VALUE  = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] WRITE_VALUE = {VAL_W{1'b0}};

    // command broadcast to every entry cell
    typedef struct packed {
        logic touch;   // key hit: move matching entry to most recent
        logic insert;  // key miss on a write: place new entry
        logic store;   // overwrite value of the matching entry
    } cell_cmd_t;

endpackage

// File: hdl/lkv_cell.sv
// one cache entry: key, value, valid flag and recency rank
// depends on lkv_pkg
module lkv_cell #(
    parameter int RANK_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lkv_pkg::cell_cmd_t         cmd,
    input  logic                       pick,
    input  logic                       kill,
    input  logic [lkv_pkg::KEY_W-1:0]  key,
    input  logic [lkv_pkg::VAL_W-1:0]  value,
    input  logic [RANK_W-1:0]          hit_rank,
    output logic                       match,
    output logic                       valid,
    output logic [RANK_W-1:0]          rank,
    output logic [lkv_pkg::VAL_W-1:0]  stored_value
);
    import lkv_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [RANK_W-1:0] rank_reg;
    logic [RANK_W-1:0] rank_next;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              load_key;
    logic              load_value;

    assign match        = valid_reg && (key_reg == key);
    assign valid        = valid_reg;
    assign rank         = rank_reg;
    assign stored_value = value_reg;

    assign load_key   = cmd.insert && pick;
    assign load_value = load_key || (cmd.touch && cmd.store && match);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (cmd.touch)
        begin
            if (match)
            begin
                rank_next = '0;
            end
            else if (valid_reg && (rank_reg < hit_rank))
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
        else if (cmd.insert)
        begin
            if (pick)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (kill)
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            else if (valid_reg)
            begin
                rank_next = rank_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_key)
        begin
            key_reg <= key;
        end
        if (load_value)
        begin
            value_reg <= value;
        end
    end

endmodule

// File: hdl/lkv_array.sv
// row of entry cells with parallel key compare, victim and free slot choice
// depends on lkv_pkg and lkv_cell
module lkv_array #(
    parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES,
    parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic                       mode,
    input  logic [lkv_pkg::KEY_W-1:0]  key,
    input  logic [lkv_pkg::VAL_W-1:0]  value,
    input  logic                       evict,
    input  logic [CNT_W-1:0]           occupancy,
    output logic                       hit,
    output logic [lkv_pkg::VAL_W-1:0]  hit_value,
    output logic [ENTRIES-1:0]         valid_vec
);
    import lkv_pkg::*;

    cell_cmd_t          cmd;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] pick_vec;
    logic [RANK_W-1:0]  rank_arr [ENTRIES];
    logic [VAL_W-1:0]   value_arr [ENTRIES];
    logic [RANK_W-1:0]  hit_rank;
    logic [CNT_W-1:0]   lru_rank;

    assign lru_rank = occupancy - CNT_W'(1);
    assign hit      = |match_vec;

    assign cmd.touch  = go && hit;
    assign cmd.insert = go && (mode == MODE_PUT) && !hit;
    assign cmd.store  = (mode == MODE_PUT);

    // lowest free slot, the victim counts as free when evicting
    assign free_vec = ~valid_vec | (evict ? victim_vec : '0);
    assign pick_vec = free_vec & (~free_vec + ENTRIES'(1));

    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_rank  = hit_rank | (rank_arr[i] & {RANK_W{match_vec[i]}});
            hit_value = hit_value | (value_arr[i] & {VAL_W{match_vec[i]}});
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        assign victim_vec[g] = valid_vec[g] && (CNT_W'(rank_arr[g]) == lru_rank);

        lkv_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .pick         (pick_vec[g]),
            .kill         (evict && victim_vec[g]),
            .key          (key),
            .value        (value),
            .hit_rank     (hit_rank),
            .match        (match_vec[g]),
            .valid        (valid_vec[g]),
            .rank         (rank_arr[g]),
            .stored_value (value_arr[g])
        );
    end

endmodule

// File: hdl/lru_key_value_cache.sv
// top level of the lru key/value cache: input and result registers, capacity, occupancy
// depends on lkv_pkg and lkv_array
//
// Fully associative key/value store with least-recently-used replacement. Every
// accepted beat (lookup or write) gives exactly one result beat, which passes through
// the input register and then the result register; a new beat can be accepted every
// cycle while in_stall is low. The key compare across all entries, the recency rank
// update and the victim/free slot choice are combinational between the
// input register and the result register. The store is empty after reset with no
// clearing pass. The capacity register may only be written while the block is idle;
// zero acts as one and values above ENTRIES act as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  write_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         capacity_in_use
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_mode_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic [VAL_W-1:0]   in_value_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_hit_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [VAL_W-1:0]   out_value_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               go;
    logic               in_take;
    logic               evict;
    logic               arr_hit;
    logic [VAL_W-1:0]   arr_value;
    logic [ENTRIES-1:0] valid_vec;

    assign go        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !go;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_value_reg;

    assign cap_ext = CMP_W'(cap_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict = (CMP_W'(occ_reg) >= eff_cap);

    lkv_array #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .CNT_W   (CNT_W)
    ) u_array (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .mode      (in_mode_reg),
        .key       (in_key_reg),
        .value     (in_value_reg),
        .evict     (evict),
        .occupancy (occ_reg),
        .hit       (arr_hit),
        .hit_value (arr_value),
        .valid_vec (valid_vec)
    );

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !go);
        out_valid_next = go || (out_valid_reg && out_stall);
        occ_next       = occ_reg;
        if (go && (in_mode_reg == MODE_PUT) && !arr_hit && !evict)
        begin
            occ_next = occ_reg + CNT_W'(1);
        end
        if (in_mode_reg == MODE_PUT)
        begin
            out_value_next = WRITE_VALUE;
        end
        else if (arr_hit)
        begin
            out_value_next = arr_value;
        end
        else
        begin
            out_value_next = MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            occ_reg       <= occ_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg  <= mode;
            in_key_reg   <= lookup_key;
            in_value_reg <= write_value;
        end
        if (go)
        begin
            out_hit_reg   <= arr_hit;
            out_value_reg <= out_value_next;
        end
    end

    // occupancy tracks the valid entries
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy does not match valid entry count");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_get_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (in_mode_reg == MODE_GET)) |=> $stable(occ_reg))
        else $error("lookup changed occupancy");

    a_put_miss_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (in_mode_reg == MODE_PUT) && !arr_hit && !evict)
        |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert without eviction did not grow occupancy");

endmodule
